@@ rtl/text_word_frequency_counter_top_macros.svh @@
// Assertion macros used by the top-level RTL file.
`ifndef TEXT_WORD_FREQUENCY_COUNTER_TOP_MACROS_SVH
`define TEXT_WORD_FREQUENCY_COUNTER_TOP_MACROS_SVH
`ifndef SYNTHESIS
`define TWFC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define TWFC_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define TWFC_ASSERT(label, prop, msg)
`define TWFC_ASSERT_ALWAYS(label, prop, msg)
`endif
`endif

@@ rtl/twfc_pkg.sv @@
package twfc_pkg;

  typedef enum logic [1:0] {
    KIND_COUNTED = 2'd0,
    KIND_DROPPED = 2'd1,
    KIND_TOTALS  = 2'd2
  } kind_t;

  typedef enum logic [4:0] {
    ST_IDLE     = 5'b00001,
    ST_SCAN_RD  = 5'b00010,
    ST_SCAN_CMP = 5'b00100,
    ST_EMIT     = 5'b01000,
    ST_TOTAL    = 5'b10000
  } state_t;

  localparam logic [31:0] SAT32 = 32'hFFFF_FFFF;

  function automatic logic [31:0] sat_inc(input logic [31:0] v);
    return (v == SAT32) ? v : v + 32'd1;
  endfunction

endpackage

@@ rtl/text_word_frequency_counter_top.sv @@
// Word frequency counter over a byte stream.
// Input channel s_axis: one text byte per word in tdata[7:0]; tlast high marks
// the end of the text and carries no byte. Output channel m_axis: one result
// per word; tuser gives the kind (counted, dropped, totals), tlast marks the
// final result caused by an input word.
// A letter or digit, or a delimiter that closes no word, is taken while the
// control stays idle. A delimiter that closes a word scans the distinct-word
// table in its row memory, a read then a compare state per stored entry,
// until a match or the fill count, then loads its result in the emit state.
// The end word adds a totals result. Input is taken only while the control
// is idle; one word is worked on at a time.
// The output register holds a result until the receiver takes it; a stall
// holds the control in its emit or totals state and blocks new input.
// Reset clears all counters, the open word and the table fill count; the
// table memory itself needs no clearing, entries past the fill count are
// never read for a match. The end word clears the same state for the next text.
`include "text_word_frequency_counter_top_macros.svh"
module text_word_frequency_counter_top #(
  parameter int TABLE_ENTRIES = 64,
  parameter int WORD_CHARS    = 16
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [7:0]   s_axis_tdata,   // text_byte[7:0]
  input  logic         s_axis_tlast,   // end_of_text
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // word_slot[5:0], word_occurrences[37:6], word_truncated[38], letter_total[70:39],
  // digit_total[102:71], length_total[134:103], distinct_total[141:135], zero pad
  output logic [143:0] m_axis_tdata,
  output logic [1:0]   m_axis_tuser,   // result_kind[1:0]
  output logic         m_axis_tlast    // last_result
);
  import twfc_pkg::*;

  localparam int AW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int DW = $clog2(TABLE_ENTRIES + 1);
  localparam int IW = $clog2(WORD_CHARS);
  localparam int LW = $clog2(WORD_CHARS + 1);
  localparam int RW = LW + WORD_CHARS * 8;

  state_t state;
  logic [WORD_CHARS-1:0][7:0] open_chars;
  logic [LW-1:0] open_len;
  logic          overflow;
  logic          in_word;
  logic [31:0]   letters, digits, bytes_cnt;
  logic [DW-1:0] distinct;
  logic [DW-1:0] idx;
  logic          pend;
  logic          hit;
  logic [31:0]   count_new;

  logic [5:0]    o_slot;
  logic [31:0]   o_occ, o_let, o_dig, o_len;
  logic          o_trunc;
  logic [6:0]    o_dist;
  kind_t         o_kind;
  logic          o_last;

  logic [RW-1:0] rd_row, open_row;
  logic [31:0]   rd_count;
  logic          wr_en, out_free, is_letter, is_digit, has_room, load;

  assign s_axis_tready = (state == ST_IDLE);
  assign out_free  = !m_axis_tvalid || m_axis_tready;
  assign load      = ((state == ST_EMIT) || (state == ST_TOTAL)) && out_free;
  assign open_row  = {open_len, open_chars};
  assign has_room  = distinct < DW'(TABLE_ENTRIES);
  assign is_letter = (s_axis_tdata >= 8'h41 && s_axis_tdata <= 8'h5A) ||
                     (s_axis_tdata >= 8'h61 && s_axis_tdata <= 8'h7A);
  assign is_digit  = (s_axis_tdata >= 8'h30 && s_axis_tdata <= 8'h39);
  assign wr_en     = (state == ST_EMIT) && out_free && (hit || has_room);

  twfc_table #(.ENTRIES(TABLE_ENTRIES), .AW(AW), .RW(RW)) u_table (
    .clk      (clk),
    .rd_addr  (idx[AW-1:0]),
    .rd_row   (rd_row),
    .rd_count (rd_count),
    .wr_en    (wr_en),
    .wr_addr  (hit ? idx[AW-1:0] : distinct[AW-1:0]),
    .wr_row   (open_row),
    .wr_count (hit ? count_new : 32'd1)
  );

  assign m_axis_tdata = {2'b00, o_dist, o_len, o_dig, o_let, o_trunc, o_occ, o_slot};
  assign m_axis_tuser = o_kind;
  assign m_axis_tlast = o_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      m_axis_tvalid <= 1'b0;
      open_chars    <= '0;
      open_len      <= '0;
      overflow      <= 1'b0;
      in_word       <= 1'b0;
      letters       <= '0;
      digits        <= '0;
      bytes_cnt     <= '0;
      distinct      <= '0;
      idx           <= '0;
      pend          <= 1'b0;
      hit           <= 1'b0;
    end else begin
      if (load) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (s_axis_tvalid) begin
            if (s_axis_tlast) begin
              pend <= 1'b1;
              idx  <= '0;
              state <= in_word ? ST_SCAN_RD : ST_TOTAL;
            end else begin
              pend      <= 1'b0;
              bytes_cnt <= sat_inc(bytes_cnt);
              if (is_letter || is_digit) begin
                if (is_letter) letters <= sat_inc(letters);
                else digits <= sat_inc(digits);
                in_word <= 1'b1;
                if (open_len < LW'(WORD_CHARS)) begin
                  open_chars[open_len[IW-1:0]] <= s_axis_tdata;
                  open_len <= open_len + LW'(1);
                end else begin
                  overflow <= 1'b1;
                end
              end else if (in_word) begin
                idx   <= '0;
                state <= ST_SCAN_RD;
              end
            end
          end
        end
        ST_SCAN_RD: begin
          if (idx == distinct) begin
            hit   <= 1'b0;
            state <= ST_EMIT;
          end else begin
            state <= ST_SCAN_CMP;
          end
        end
        ST_SCAN_CMP: begin
          count_new <= sat_inc(rd_count);
          if (rd_row == open_row) begin
            hit   <= 1'b1;
            state <= ST_EMIT;
          end else begin
            idx   <= idx + DW'(1);
            state <= ST_SCAN_RD;
          end
        end
        ST_EMIT: begin
          if (out_free) begin
            o_trunc <= overflow;
            o_let   <= '0;
            o_dig   <= '0;
            o_len   <= '0;
            o_dist  <= '0;
            o_last  <= !pend;
            if (hit) begin
              o_kind <= KIND_COUNTED;
              o_slot <= 6'(idx);
              o_occ  <= count_new;
            end else if (has_room) begin
              o_kind   <= KIND_COUNTED;
              o_slot   <= 6'(distinct);
              o_occ    <= 32'd1;
              distinct <= distinct + DW'(1);
            end else begin
              o_kind <= KIND_DROPPED;
              o_slot <= '0;
              o_occ  <= '0;
            end
            open_chars <= '0;
            open_len   <= '0;
            overflow   <= 1'b0;
            in_word    <= 1'b0;
            state      <= pend ? ST_TOTAL : ST_IDLE;
          end
        end
        ST_TOTAL: begin
          if (out_free) begin
            o_kind  <= KIND_TOTALS;
            o_slot  <= '0;
            o_occ   <= '0;
            o_trunc <= 1'b0;
            o_let   <= letters;
            o_dig   <= digits;
            o_len   <= bytes_cnt;
            o_dist  <= 7'(distinct);
            o_last  <= 1'b1;
            letters   <= '0;
            digits    <= '0;
            bytes_cnt <= '0;
            distinct  <= '0;
            pend      <= 1'b0;
            state     <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  `TWFC_ASSERT(a_fill_bound, distinct <= DW'(TABLE_ENTRIES), "table fill count past depth")
  `TWFC_ASSERT(a_scan_bound, (state == ST_SCAN_RD) |-> (idx <= distinct), "scan past fill count")
  `TWFC_ASSERT(a_open_bound, open_len <= LW'(WORD_CHARS), "open word length past store")
  `TWFC_ASSERT(a_totals_last, (m_axis_tvalid && m_axis_tuser == KIND_TOTALS) |-> m_axis_tlast,
               "totals result without last flag")
  `TWFC_ASSERT(a_totals_clear, (state == ST_TOTAL && out_free) |=> (distinct == '0 && !in_word),
               "state not cleared after totals")

endmodule

@@ rtl/twfc_table.sv @@
module twfc_table #(
  parameter int ENTRIES = 64,
  parameter int AW      = 6,
  parameter int RW      = 133
) (
  input  logic          clk,
  input  logic [AW-1:0] rd_addr,
  output logic [RW-1:0] rd_row,
  output logic [31:0]   rd_count,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [RW-1:0] wr_row,
  input  logic [31:0]   wr_count
);

  logic [RW-1:0] rows   [ENTRIES];
  logic [31:0]   counts [ENTRIES];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      rows[wr_addr]   <= wr_row;
      counts[wr_addr] <= wr_count;
    end
    rd_row   <= rows[rd_addr];
    rd_count <= counts[rd_addr];
  end

endmodule

@@ dv/text_word_frequency_counter_top_test.sv @@
module text_word_frequency_counter_top_test;
  import twfc_pkg::*;

  localparam int TABLE_ENTRIES = 64;
  localparam int WORD_CHARS = 16;
  localparam int CYCLE_LIMIT = 1000000;

  typedef struct packed {
    kind_t       kind;
    logic [5:0]  slot;
    logic [31:0] occurrences;
    logic        truncated;
    logic [31:0] letters;
    logic [31:0] digits;
    logic [31:0] length;
    logic [6:0]  distinct;
    logic        last;
  } word_result_t;

  int error_count = 0;

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch %s: got %0h want %0h", what, got, want);
    error_count++;
  endtask

  class word_count_board;
    logic [7:0]  table_chars[TABLE_ENTRIES][WORD_CHARS];
    int          table_len[TABLE_ENTRIES];
    logic [31:0] table_count[TABLE_ENTRIES];
    logic [7:0]  open_chars[WORD_CHARS];
    int          open_len;
    bit          open_cut;
    bit          in_word;
    logic [31:0] letters, digits, length;
    int          distinct;
    word_result_t pending[$];

    function void clear();
      open_len = 0;
      open_cut = 0;
      in_word = 0;
      letters = 0;
      digits = 0;
      length = 0;
      distinct = 0;
    endfunction

    function logic [31:0] bump(logic [31:0] v);
      return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
    endfunction

    function word_result_t close_word();
      word_result_t r;
      int hit;
      bit same;
      r = '0;
      r.truncated = open_cut;
      hit = -1;
      for (int s = 0; s < distinct && hit < 0; s++) begin
        same = (table_len[s] == open_len);
        for (int i = 0; i < open_len; i++)
          if (table_chars[s][i] != open_chars[i]) same = 0;
        if (same) hit = s;
      end
      if (hit >= 0) begin
        table_count[hit] = bump(table_count[hit]);
        r.kind = KIND_COUNTED;
        r.slot = hit[5:0];
        r.occurrences = table_count[hit];
      end else if (distinct < TABLE_ENTRIES) begin
        for (int i = 0; i < open_len; i++) table_chars[distinct][i] = open_chars[i];
        table_len[distinct] = open_len;
        table_count[distinct] = 1;
        r.kind = KIND_COUNTED;
        r.slot = distinct[5:0];
        r.occurrences = 1;
        distinct++;
      end else begin
        r.kind = KIND_DROPPED;
      end
      in_word = 0;
      open_len = 0;
      open_cut = 0;
      return r;
    endfunction

    function void note_input(logic [7:0] c, logic eot);
      word_result_t r;
      bit letter, digit;
      if (eot) begin
        if (in_word) pending.push_back(close_word());
        r = '0;
        r.kind = KIND_TOTALS;
        r.letters = letters;
        r.digits = digits;
        r.length = length;
        r.distinct = distinct[6:0];
        r.last = 1;
        pending.push_back(r);
        clear();
        return;
      end
      length = bump(length);
      letter = (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
      digit = c >= "0" && c <= "9";
      if (letter || digit) begin
        if (letter) letters = bump(letters);
        else digits = bump(digits);
        in_word = 1;
        if (open_len < WORD_CHARS) begin
          open_chars[open_len] = c;
          open_len++;
        end else begin
          open_cut = 1;
        end
      end else if (in_word) begin
        r = close_word();
        r.last = 1;
        pending.push_back(r);
      end
    endfunction

    task check_result(logic [1:0] kind, logic [143:0] data, logic last);
      word_result_t w;
      if (pending.size() == 0) begin
        report_mismatch("unexpected result kind", 32'(kind), 32'd0);
        return;
      end
      w = pending.pop_front();
      if (kind != w.kind) report_mismatch("kind", 32'(kind), 32'(w.kind));
      if (data[5:0] != w.slot) report_mismatch("slot", 32'(data[5:0]), 32'(w.slot));
      if (data[37:6] != w.occurrences)
        report_mismatch("occurrences", data[37:6], w.occurrences);
      if (data[38] != w.truncated)
        report_mismatch("truncated", 32'(data[38]), 32'(w.truncated));
      if (data[70:39] != w.letters) report_mismatch("letters", data[70:39], w.letters);
      if (data[102:71] != w.digits) report_mismatch("digits", data[102:71], w.digits);
      if (data[134:103] != w.length) report_mismatch("length", data[134:103], w.length);
      if (data[141:135] != w.distinct)
        report_mismatch("distinct", 32'(data[141:135]), 32'(w.distinct));
      if (data[143:142] != 2'b00) report_mismatch("pad", 32'(data[143:142]), 32'd0);
      if (last != w.last) report_mismatch("last", 32'(last), 32'(w.last));
    endtask
  endclass

  logic         clk = 0;
  logic         rst = 1;
  logic         s_axis_tvalid = 0;
  logic         s_axis_tready;
  logic [7:0]   s_axis_tdata = '0;
  logic         s_axis_tlast = 0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 0;
  logic [143:0] m_axis_tdata;
  logic [1:0]   m_axis_tuser;
  logic         m_axis_tlast;

  text_word_frequency_counter_top #(
    .TABLE_ENTRIES(TABLE_ENTRIES),
    .WORD_CHARS(WORD_CHARS)
  ) dut (.*);

  word_count_board board = new();
  int cycles = 0;

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready)
      board.check_result(m_axis_tuser, m_axis_tdata, m_axis_tlast);
  end

  // receiver stall pattern: random stretches, from always ready to mostly stalled
  initial begin
    int mode;
    @(posedge clk);
    forever begin
      mode = $urandom_range(0, 3);
      repeat ($urandom_range(1, 40)) begin
        @(posedge clk);
        case (mode)
          0: m_axis_tready <= 1;
          1: m_axis_tready <= ($urandom_range(0, 3) != 0);
          2: m_axis_tready <= $urandom_range(0, 1);
          default: m_axis_tready <= ($urandom_range(0, 7) == 0);
        endcase
      end
    end
  end

  int burst_left = 0;

  task automatic send_word(input logic [7:0] c, input logic eot);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        s_axis_tvalid <= 0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 30);
    end
    s_axis_tvalid <= 1;
    s_axis_tdata <= c;
    s_axis_tlast <= eot;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    board.note_input(c, eot);
    burst_left--;
  endtask

  function automatic logic [7:0] pick_char(int k);
    case (k)
      0: return 8'($urandom_range("a", "z"));
      1: return 8'($urandom_range("A", "Z"));
      2: return 8'($urandom_range("0", "9"));
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_word(s[i], 0);
  endtask

  initial begin
    int sent;
    int vocab_len[8];
    logic [7:0] vocab[8][20];
    int v, n;
    board.clear();
    repeat (8) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // empty text, short words, repeats, long words, zero byte, high bytes
    send_word(8'hFF, 1);
    send_text("Az 09 Az");
    send_word(8'h00, 0);
    send_word(8'h80, 0);
    send_text("ABCDEFGHIJKLMNOPQRz");
    send_word(8'h7F, 0);
    send_text("abcdefghijklmnopqrz");
    send_word(8'h55, 1);
    sent = 51;

    // table overflow: 66 distinct words, then a repeat and a new word
    for (int w = 0; w < 66; w++) begin
      send_word("w", 0);
      send_word(8'("0" + w / 10), 0);
      send_word(8'("0" + w % 10), 0);
      send_word(" ", 0);
    end
    send_text("w05 zz");
    send_word(8'h00, 1);
    sent += 271;

    // random texts built mostly from a small vocabulary
    while (sent < 550) begin
      for (int i = 0; i < 8; i++) begin
        vocab_len[i] = ($urandom_range(0, 9) == 0) ? $urandom_range(15, 20)
                                                   : $urandom_range(1, 5);
        for (int j = 0; j < 20; j++) vocab[i][j] = pick_char($urandom_range(0, 2));
      end
      n = $urandom_range(3, 30);
      for (int t = 0; t < n; t++) begin
        if ($urandom_range(0, 4) == 0) begin
          send_word(pick_char(3), 0);
          sent++;
        end else begin
          v = $urandom_range(0, 7);
          for (int j = 0; j < vocab_len[v]; j++) send_word(vocab[v][j], 0);
          send_word(($urandom_range(0, 1)) ? " " : pick_char(3) & 8'h2F, 0);
          sent += vocab_len[v] + 1;
        end
      end
      send_word(pick_char(3), 1);
      sent++;
    end
    s_axis_tvalid <= 0;
    s_axis_tlast <= 0;

    while (board.pending.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    if (error_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

@@ files.f @@
+incdir+rtl
rtl/twfc_pkg.sv
rtl/twfc_table.sv
rtl/text_word_frequency_counter_top.sv
dv/text_word_frequency_counter_top_test.sv
